>>> hw/rtl/scanner_pixel_unpacker_core_defines.svh
// Assertion macros used by the pixel unpacker back end
`ifndef SCANNER_PIXEL_UNPACKER_CORE_DEFINES_SVH
`define SCANNER_PIXEL_UNPACKER_CORE_DEFINES_SVH

// same-cycle implication, reset-qualified
`define SPU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset-qualified
`define SPU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/spu_pkg.sv
// Shared types and constants for the scanner pixel unpacker
`timescale 1ns / 1ps

package spu_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] FMT_GRAY  = 3'd0;
	localparam logic [2:0] FMT_RGB   = 3'd1;
	localparam logic [2:0] FMT_RED   = 3'd2;
	localparam logic [2:0] FMT_GREEN = 3'd3;
	localparam logic [2:0] FMT_BLUE  = 3'd4;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_GRAY8  = 2'd1;
	localparam logic [1:0] REG_PPL    = 2'd2;
	localparam logic [1:0] REG_LINES  = 2'd3;

	localparam logic [2:0] MASK_ALL   = 3'b111;
	localparam logic [2:0] MASK_RED   = 3'b100;
	localparam logic [2:0] MASK_GREEN = 3'b010;
	localparam logic [2:0] MASK_BLUE  = 3'b001;

	typedef enum logic [1:0] {
		JOB_CLEAR,
		JOB_PIXEL,
		JOB_LINEART
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [23:0] value;
		logic [2:0]  mask;
	} job_t;

endpackage

>>> hw/rtl/spu_front.sv
// Front end: accepts beats, gathers rgb triplets, issues pixel, lineart and clear jobs
`timescale 1ns / 1ps

module spu_front import spu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [7:0] data_byte,
	input  logic [2:0] frame_format,
	input  logic       gray_is_eight_bit,
	input  logic       queue_full,
	output logic       push,
	output job_t       job
);

	logic [7:0] held_q [2];
	logic [1:0] held_cnt_q;
	logic       accept;
	logic       has_job;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && has_job;

	always_comb begin
		has_job    = 1'b0;
		job.kind   = JOB_PIXEL;
		job.value  = {16'd0, data_byte};
		job.mask   = MASK_ALL;
		if (command) begin
			has_job  = 1'b1;
			job.kind = JOB_CLEAR;
		end else begin
			unique case (frame_format)
				FMT_GRAY: begin
					has_job  = 1'b1;
					job.kind = gray_is_eight_bit ? JOB_PIXEL : JOB_LINEART;
				end
				FMT_RGB: begin
					has_job   = (held_cnt_q == 2'd2);
					job.value = {held_q[0], held_q[1], data_byte};
				end
				FMT_RED: begin
					has_job   = 1'b1;
					job.value = {data_byte, 16'd0};
					job.mask  = MASK_RED;
				end
				FMT_GREEN: begin
					has_job   = 1'b1;
					job.value = {8'd0, data_byte, 8'd0};
					job.mask  = MASK_GREEN;
				end
				FMT_BLUE: begin
					has_job  = 1'b1;
					job.mask = MASK_BLUE;
				end
				default: has_job = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			held_q[0]  <= 8'd0;
			held_q[1]  <= 8'd0;
		end else if (accept) begin
			if (command) begin
				held_cnt_q <= 2'd0;
				held_q[0]  <= 8'd0;
				held_q[1]  <= 8'd0;
			end else if (frame_format == FMT_RGB) begin
				if (held_cnt_q == 2'd2) begin
					held_cnt_q <= 2'd0;
				end else begin
					held_q[held_cnt_q[0]] <= data_byte;
					held_cnt_q            <= held_cnt_q + 2'd1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/spu_queue.sv
// Short job queue between front and back end
`timescale 1ns / 1ps

module spu_queue import spu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output job_t head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	job_t            mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full      = (count_q == CNTW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/spu_back.sv
// Back end: tracks position, expands jobs into pixel write beats
`timescale 1ns / 1ps

`include "scanner_pixel_unpacker_core_defines.svh"

module spu_back import spu_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_pop,
	input  logic [15:0] line_pixels,
	input  logic [15:0] line_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] column,
	output logic [15:0] row,
	output logic [23:0] pixel_value,
	output logic [2:0]  channel_mask,
	output logic        last_of_item
);

	localparam int CW = (COORD_BITS > 16) ? COORD_BITS : 16;

	logic [COORD_BITS-1:0] x_q, y_q;
	logic [COORD_BITS-1:0] x_pl, y_pl, x_inc, y_inc;
	logic [2:0]            bit_q;
	logic                  wrap, y_in, ok, next_ok, is_line, is_clear;
	logic                  last, done, out_free, step, load, spill;
	logic                  out_valid_q;
	logic [15:0]           column_q, row_q;
	logic [23:0]           value_q;
	logic [2:0]            mask_q;
	logic                  last_q;

	always_comb begin
		is_line  = (job.kind == JOB_LINEART);
		is_clear = (job.kind == JOB_CLEAR);
		wrap     = CW'(x_q) >= CW'(line_pixels);
		x_pl     = wrap ? '0 : x_q;
		y_pl     = wrap ? y_q + COORD_BITS'(1) : y_q;
		y_in     = CW'(y_q) < CW'(line_count);
		ok       = y_in && (CW'(y_pl) < CW'(line_count));
		x_inc    = x_pl + COORD_BITS'(1);
		y_inc    = y_pl + COORD_BITS'(1);
		next_ok  = (CW'(x_inc) < CW'(line_pixels)) || (CW'(y_inc) < CW'(line_count));
		last     = !is_line || (bit_q == 3'd7) || !next_ok;
		// lineart byte cut short: the next bit still wraps onto the row past the end
		spill    = ok && is_line && (bit_q != 3'd7) && !next_ok;
		done     = !ok || last;
		out_free = !out_valid_q || out_ready;
		step     = job_valid && (is_clear || out_free);
		load     = step && !is_clear && ok;
		job_pop  = step && (is_clear || done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			y_q         <= '0;
			bit_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				if (is_clear) begin
					x_q   <= '0;
					y_q   <= '0;
					bit_q <= 3'd0;
				end else begin
					if (y_in) begin
						x_q <= spill ? '0 : (ok ? x_inc : x_pl);
						y_q <= spill ? y_inc : y_pl;
					end
					bit_q <= done ? 3'd0 : bit_q + 3'd1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			column_q <= 16'(x_pl);
			row_q    <= 16'(y_pl);
			value_q  <= is_line ? {23'd0, !job.value[3'd7 - bit_q]} : job.value;
			mask_q   <= is_line ? MASK_ALL : job.mask;
			last_q   <= last;
		end
	end

	assign out_valid    = out_valid_q;
	assign column       = column_q;
	assign row          = row_q;
	assign pixel_value  = value_q;
	assign channel_mask = mask_q;
	assign last_of_item = last_q;

	`SPU_ASSERT_NOW(a_bit_in_lineart, bit_q != 3'd0, job_valid && is_line, "bit count without lineart job")
	`SPU_ASSERT_NEXT(a_clear_pos, step && is_clear, x_q == '0 && y_q == '0, "start did not clear position")
	`SPU_ASSERT_NEXT(a_rows_done, step && !is_clear && !y_in, $stable(y_q) && $stable(x_q), "position moved past last line")

endmodule

>>> hw/rtl/scanner_pixel_unpacker_core.sv
// Scanner pixel unpacker top level: config registers, front, queue, back
//
//  channel | signals                                              | dir
//  input   | in_valid, in_ready, command, data_byte               | in
//  output  | out_valid, out_ready, column, row, pixel_value,      | out
//          | channel_mask, last_of_item                           |
//  config  | cfg_we, cfg_index, cfg_wdata                         | in
//
// Gray, rgb and single-color beats are taken one per cycle while the queue is not
// full; each pixel write leaves through a registered output stage. A lineart byte
// holds the back end for up to eight pixel writes, one per cycle while the output
// does not stall, ending early when the frame runs out of lines; the two-entry job
// queue absorbs this. Reset clears position, held rgb bytes, the queue and the output
// stage; config resets to gray 8-bit, one pixel per line, one line. An output stall
// holds the back end, clear jobs apart; the input stalls only once the queue is full.
`timescale 1ns / 1ps

module scanner_pixel_unpacker_core import spu_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] column,
	output logic [15:0] row,
	output logic [23:0] pixel_value,
	output logic [2:0]  channel_mask,
	output logic        last_of_item
);

	logic [2:0]  format_q;
	logic        gray8_q;
	logic [15:0] ppl_q;
	logic [15:0] lines_q;

	logic queue_full, queue_ne, push, pop;
	job_t push_job, head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_GRAY;
			gray8_q  <= 1'b1;
			ppl_q    <= 16'd1;
			lines_q  <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORMAT: format_q <= cfg_wdata[2:0];
				REG_GRAY8:  gray8_q  <= cfg_wdata[0];
				REG_PPL:    ppl_q    <= cfg_wdata;
				REG_LINES:  lines_q  <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	spu_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.command           (command),
		.data_byte         (data_byte),
		.frame_format      (format_q),
		.gray_is_eight_bit (gray8_q),
		.queue_full        (queue_full),
		.push              (push),
		.job               (push_job)
	);

	spu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_ne),
		.head      (head_job)
	);

	spu_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (queue_ne),
		.job          (head_job),
		.job_pop      (pop),
		.line_pixels  (ppl_q),
		.line_count   (lines_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column       (column),
		.row          (row),
		.pixel_value  (pixel_value),
		.channel_mask (channel_mask),
		.last_of_item (last_of_item)
	);

endmodule
